### src/assert_macros.svh
// Assertion macros shared by the RTL in this folder.
// Compiled out when SYNTH is defined; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

### src/iir_df1_pkg.sv
// Types and constants for the direct-form-I IIR filter.
// No dependencies; imported by iir_direct_form_one_filter.
package iir_df1_pkg;

  localparam int SMP_W   = 16;   // Q1.15 input
  localparam int COEF_W  = 32;   // Q8.24 weights
  localparam int OUT_W   = 24;   // Q9.15 output
  localparam int FRAC_SH = 24;   // Q.39 sum down to Q.15
  localparam int ACC_W   = 60;   // seven exact products, no overflow
  localparam int CFG_IDX_W = 3;

  localparam logic [COEF_W-1:0] COEF_ONE = 32'h0100_0000;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_B0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_B3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_A1 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_A2 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_A3 = 3'd6;

  localparam logic signed [OUT_W-1:0] OUT_MAX = 24'sh7F_FFFF;
  localparam logic signed [OUT_W-1:0] OUT_MIN = 24'sh80_0000;

  typedef struct packed {
    logic signed [SMP_W-1:0] sample;
    logic                    clear_history;
  } smp_word_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] filtered;
    logic        [OUT_W-1:0] peak_magnitude;
    logic                    saturated;
  } res_word_t;

endpackage

### src/iir_direct_form_one_filter.sv
// Direct-form-I IIR filter of order TAPS with saturated Q9.15 output and
// running peak magnitude. Depends on iir_df1_pkg and assert_macros.svh.
// Usage:
//   Sample channel (smp_valid / smp_stall / smp): one Q1.15 sample per word,
//   taken at a rising edge with smp_valid high and smp_stall low. A set
//   clear_history bit zeroes both histories and the peak before the sample.
//   Result channel (res_valid / res_stall / res): one word per sample with
//   the filtered output, the peak |output| since the last clear and a clip
//   flag.
//   Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): writes
//   the Q8.24 weights b0..b3, a1..a3 at indexes 0..6; index 7 is ignored.
//   cfg_ready is always high. Write only while no sample is in flight.
// Timing: a taken sample waits in the input register and moves on to the
//   result register when it advances. One sample per cycle sustained while
//   the result is not stalled: the seven products, the sum, rounding and
//   saturation fit between the input register and the result register, which also closes the output feedback loop.
// Stall: a stalled result holds; the input register still takes one more
//   word, then smp_stall rises until the result moves.
// Reset (rst, synchronous): histories and peak cleared, b0 = 1.0, other
//   weights zero, both channels empty.
`include "assert_macros.svh"

module iir_direct_form_one_filter #(
  parameter int TAPS = 3
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   smp_valid,
  output logic                                   smp_stall,
  input  iir_df1_pkg::smp_word_t                 smp,
  output logic                                   res_valid,
  input  logic                                   res_stall,
  output iir_df1_pkg::res_word_t                 res,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [iir_df1_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [iir_df1_pkg::COEF_W-1:0]         cfg_data
);
  import iir_df1_pkg::*;

  localparam int XP_W = COEF_W + SMP_W;   // b * x product
  localparam int YP_W = COEF_W + OUT_W;   // a * y product
  localparam int Y_W  = ACC_W - FRAC_SH;

  // weights
  logic signed [COEF_W-1:0] coef_b [0:3];
  logic signed [COEF_W-1:0] coef_a [1:3];

  // histories, entry 0 is the newest
  logic signed [SMP_W-1:0] x_hist [0:TAPS-1];
  logic signed [OUT_W-1:0] y_hist [0:TAPS-1];
  logic        [OUT_W-1:0] peak;

  // input register
  logic      s1_valid;
  smp_word_t s1;

  logic advance;
  logic take;

  logic signed [XP_W-1:0]  xprod [0:TAPS];
  logic signed [YP_W-1:0]  yprod [1:TAPS];
  logic signed [ACC_W-1:0] acc;
  logic signed [Y_W-1:0]   y_wide;
  logic signed [OUT_W-1:0] y_sat;
  logic                    clip;
  logic        [OUT_W-1:0] mag;
  logic        [OUT_W-1:0] peak_base;
  logic        [OUT_W-1:0] peak_next;
  logic        [OUT_W-1:0] res_mag;

  assign cfg_ready = 1'b1;
  assign advance   = s1_valid && (!res_valid || !res_stall);
  assign smp_stall = s1_valid && res_valid && res_stall;
  assign take      = smp_valid && !smp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_b[0] <= COEF_ONE;
      coef_b[1] <= '0;
      coef_b[2] <= '0;
      coef_b[3] <= '0;
      coef_a[1] <= '0;
      coef_a[2] <= '0;
      coef_a[3] <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_B0:  coef_b[0] <= cfg_data;
        REG_B1:  coef_b[1] <= cfg_data;
        REG_B2:  coef_b[2] <= cfg_data;
        REG_B3:  coef_b[3] <= cfg_data;
        REG_A1:  coef_a[1] <= cfg_data;
        REG_A2:  coef_a[2] <= cfg_data;
        REG_A3:  coef_a[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1 <= smp;
    end
  end

  // products read the history as zero when this word clears it
  always_comb begin
    xprod[0] = coef_b[0] * s1.sample;
    for (int k = 1; k <= TAPS; k++) begin
      xprod[k] = coef_b[k] * x_hist[k-1];
      yprod[k] = coef_a[k] * y_hist[k-1];
      if (s1.clear_history) begin
        xprod[k] = '0;
        yprod[k] = '0;
      end
    end
    acc = ACC_W'(xprod[0]);
    for (int k = 1; k <= TAPS; k++) begin
      acc = acc + ACC_W'(xprod[k]) + ACC_W'(yprod[k]);
    end
    // round half up, then floor shift to Q.15
    acc    = acc + ACC_W'(1 << (FRAC_SH - 1));
    y_wide = Y_W'(acc >>> FRAC_SH);
  end

  always_comb begin
    clip = 1'b1;
    if (y_wide > Y_W'(OUT_MAX)) begin
      y_sat = OUT_MAX;
    end else if (y_wide < Y_W'(OUT_MIN)) begin
      y_sat = OUT_MIN;
    end else begin
      y_sat = OUT_W'(y_wide);
      clip  = 1'b0;
    end
    // -2^23 negates to 0x800000, which still fits unsigned
    mag       = y_sat[OUT_W-1] ? OUT_W'(~y_sat + 1'b1) : OUT_W'(y_sat);
    peak_base = s1.clear_history ? '0 : peak;
    peak_next = (mag > peak_base) ? mag : peak_base;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < TAPS; k++) begin
        x_hist[k] <= '0;
        y_hist[k] <= '0;
      end
      peak <= '0;
    end else if (advance) begin
      x_hist[0] <= s1.sample;
      y_hist[0] <= y_sat;
      for (int k = 1; k < TAPS; k++) begin
        x_hist[k] <= s1.clear_history ? '0 : x_hist[k-1];
        y_hist[k] <= s1.clear_history ? '0 : y_hist[k-1];
      end
      peak <= peak_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res.filtered       <= y_sat;
      res.peak_magnitude <= peak_next;
      res.saturated      <= clip;
    end
  end

  assign res_mag = res.filtered[OUT_W-1] ? OUT_W'(~res.filtered + 1'b1)
                                         : OUT_W'(res.filtered);

  `ASSERT_IMPL(a_clip_on_rail, clk, rst, res_valid && res.saturated, res.filtered == OUT_MAX || res.filtered == OUT_MIN)
  `ASSERT_IMPL(a_peak_covers_out, clk, rst, res_valid, res.peak_magnitude >= res_mag)
  `ASSERT_NEXT(a_held_word_kept, clk, rst, s1_valid && !advance, s1_valid && $stable(s1))
  `ASSERT_NEXT(a_stalled_result_kept, clk, rst, res_valid && res_stall, res_valid && $stable(res))

endmodule
